// ===== rtl/core/alpha_recover_and_color_bleed_core_macros.svh =====
// Assertion macros used by the checker file of the alpha recovery core.
// Depends on nothing; included by bare file name.
`ifndef ALPHA_RECOVER_AND_COLOR_BLEED_CORE_MACROS_SVH
`define ALPHA_RECOVER_AND_COLOR_BLEED_CORE_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ARCB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also watches the reset cycles.
`define ARCB_ASSERT_ON(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/arcb_pkg.sv =====
// Shared types, constants and codes of the alpha recovery and color bleed core.
// Depends on nothing; used by the divider, the top level and the checker of the block.
package arcb_pkg;

   localparam int MAX_DIM_DEFAULT       = 128;
   localparam int WINDOW_RADIUS_DEFAULT = 6;

   localparam int CHAN_W     = 8;
   localparam int NUM_CHAN   = 3;
   localparam int PIX_W      = 32;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_DATA_W-1:0] FRAME_SIZE_RESET = 8'd64;
   localparam logic [CSR_DATA_W-1:0] THRESHOLD_RESET  = 8'd84;

   // Separation arithmetic: s = sum of (255 + black - white), at most 1530.
   localparam int CHAN_MAX    = 255;
   localparam int SEP_SUM_W   = 11;
   localparam int COLOR_SCALE = 765;
   localparam int SEP_NUM_W   = 18;
   // floor(s/3) equals (s*683)>>11 for every s up to 1530.
   localparam int ALPHA_RECIP = 683;
   localparam int ALPHA_SHIFT = 11;
   localparam int APROD_W     = SEP_SUM_W + 10;
   localparam int QUOT_W      = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_SIZE = 1'b0,
      CSR_THRESHOLD  = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEP,
      ST_SDIV,
      ST_WRITE,
      ST_CTR,
      ST_WIN,
      ST_WTAIL,
      ST_WSTART,
      ST_WDIV,
      ST_EMIT,
      ST_ALIGN
   } core_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== rtl/core/arcb_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
// Depends on nothing.
module arcb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1664
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/arcb_div.sv =====
// Three-lane restoring divider giving an 8-bit quotient saturated at 255.
// Depends on arcb_pkg; one quotient bit per cycle.
module arcb_div #(
   parameter int NUM_W = 18,
   parameter int DEN_W = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [NUM_W-1:0]              num [arcb_pkg::NUM_CHAN],
   input  logic [DEN_W-1:0]              den,
   output arcb_pkg::div_status_type      status,
   output logic [arcb_pkg::QUOT_W-1:0]   quot [arcb_pkg::NUM_CHAN]
);

   localparam int CMP_W = (NUM_W > DEN_W + arcb_pkg::QUOT_W) ? NUM_W
                                                             : DEN_W + arcb_pkg::QUOT_W;
   localparam int STEP_W = $clog2(arcb_pkg::QUOT_W);

   logic [CMP_W-1:0]            rem_ff  [arcb_pkg::NUM_CHAN];
   logic [CMP_W-1:0]            rem_in  [arcb_pkg::NUM_CHAN];
   logic [arcb_pkg::QUOT_W-1:0] q_ff    [arcb_pkg::NUM_CHAN];
   logic [arcb_pkg::QUOT_W-1:0] q_in    [arcb_pkg::NUM_CHAN];
   logic                        sat_ff  [arcb_pkg::NUM_CHAN];
   logic                        sat_in  [arcb_pkg::NUM_CHAN];
   logic [DEN_W-1:0]            den_ff, den_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CMP_W-1:0]            shifted_c;

   // Load on start, then one compare and subtract per lane and cycle.
   always_comb begin
      rem_in    = rem_ff;
      q_in      = q_ff;
      sat_in    = sat_ff;
      den_in    = den_ff;
      step_in   = step_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      shifted_c = CMP_W'(den_ff) << step_ff;
      if (start) begin
         for (int k = 0; k < arcb_pkg::NUM_CHAN; k++) begin
            rem_in[k] = CMP_W'(num[k]);
            q_in[k]   = '0;
            sat_in[k] = CMP_W'(num[k]) >= (CMP_W'(den) << arcb_pkg::QUOT_W);
         end
         den_in  = den;
         step_in = STEP_W'(arcb_pkg::QUOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int k = 0; k < arcb_pkg::NUM_CHAN; k++) begin
            if (rem_ff[k] >= shifted_c) begin
               rem_in[k]        = rem_ff[k] - shifted_c;
               q_in[k][step_ff] = 1'b1;
            end
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      sat_ff  <= sat_in;
      den_ff  <= den_in;
      step_ff <= step_in;
   end

   // The quotient holds after done until the next start.
   always_comb begin
      for (int k = 0; k < arcb_pkg::NUM_CHAN; k++) begin
         quot[k] = sat_ff[k] ? {arcb_pkg::QUOT_W{1'b1}} : q_ff[k];
      end
      status.busy = busy_ff;
      status.done = done_ff;
   end

endmodule

// ===== rtl/core/alpha_recover_and_color_bleed_core.sv =====
// Top level of the alpha recovery and color bleed core: sequencer, pixel store, divider.
// Depends on arcb_pkg, arcb_ram and arcb_div.
//
//  channel | ports                     | payload
//  --------+---------------------------+------------------------------------------
//  request | req_tvalid/tready         | tdata: black r,g,b, white r,g,b; tuser: drain
//  result  | rsp_tvalid/tready         | tdata: red, green, blue, alpha; tlast: frame end
//  config  | csr_valid/ready           | csr_index, csr_data (frame size, threshold)
//
// One request at a time: it only stores, emits an opaque pixel, or for a transparent
// one scans the window and divides, paced by the single store read port that the
// window scan walks and by the 8-step divider.
// A frame size write holds off requests while the output position is realigned.
// Reset is synchronous and clears control state, not the pixel store.
// A stalled result waits in the output register while the next request is worked on.
module alpha_recover_and_color_bleed_core #(
   parameter int MAX_DIM       = arcb_pkg::MAX_DIM_DEFAULT,
   parameter int WINDOW_RADIUS = arcb_pkg::WINDOW_RADIUS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // black_red, black_green, black_blue, white_red, white_green, white_blue
   input  logic [arcb_pkg::REQ_DATA_W-1:0]  req_tdata,
   // action
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_red, out_green, out_blue, out_alpha
   output logic [arcb_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [arcb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [arcb_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int WIN    = 2 * WINDOW_RADIUS + 1;
   localparam int DEPTH  = WIN * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int CNT_W  = $clog2(MAX_DIM * MAX_DIM + WINDOW_RADIUS * MAX_DIM
                                  + WINDOW_RADIUS + 1);
   localparam int CRD_W  = DIM_W + 2;
   localparam int WI_W   = $clog2(WIN);
   localparam int WCNT_W = $clog2(WIN * WIN + 1);
   localparam int SUM_W  = $clog2(WIN * WIN * arcb_pkg::CHAN_MAX + 1);
   localparam int NUM_W  = (SUM_W > arcb_pkg::SEP_NUM_W) ? SUM_W : arcb_pkg::SEP_NUM_W;
   localparam int DEN_W  = (WCNT_W > arcb_pkg::SEP_SUM_W) ? WCNT_W : arcb_pkg::SEP_SUM_W;
   localparam int CW     = arcb_pkg::CHAN_W;
   localparam int NCH    = arcb_pkg::NUM_CHAN;

   // Configuration registers.
   logic [CW-1:0] frame_size_ff, threshold_ff;
   logic          realign_ff, realign_in;

   // Sequencer state.
   arcb_pkg::core_state_type state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  align_ff, align_in;
   logic [ADDR_W-1:0] wp_ff, wp_in;
   logic [DIM_W-1:0]  ox_ff, ox_in, oy_ff, oy_in;
   logic              act_ff, act_in;
   logic [CW-1:0]     blk_ff [NCH];
   logic [CW-1:0]     blk_in [NCH];
   logic [CW-1:0]     wht_ff [NCH];
   logic [CW-1:0]     wht_in [NCH];
   logic [arcb_pkg::SEP_SUM_W-1:0] s_ff, s_in;
   logic [CW-1:0]     alpha_ff, alpha_in;
   logic [CW-1:0]     res_ff [NCH];
   logic [CW-1:0]     res_in [NCH];
   logic [CW-1:0]     res_a_ff, res_a_in;

   // Window scan.
   logic [ADDR_W-1:0]       waddr_ff, waddr_in;
   logic [WI_W-1:0]         wi_ff, wi_in, wj_ff, wj_in;
   logic signed [CRD_W-1:0] fy_ff, fy_in, fx_ff, fx_in;
   logic                    tap_ff, tap_in;
   logic [SUM_W-1:0]        sum_ff [NCH];
   logic [SUM_W-1:0]        sum_in [NCH];
   logic [WCNT_W-1:0]       wcnt_ff, wcnt_in;

   // Output register.
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [arcb_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                             rsp_last_ff, rsp_last_in;

   // Derived values.
   logic [DIM_W-1:0]                 size_c;
   logic [CNT_W-1:0]                 total_c, lag_c;
   logic                             restart_c;
   logic [ADDR_W-1:0]                lag_a, lag2_a, center_c, start_c, wp_next_c;
   logic [ADDR_W:0]                  tmp_center, tmp_start, row_inc_c, step_sum;
   logic signed [CRD_W-1:0]          sm1_c, fy0_c, fx0_c;
   logic                             pos_ok_c, last_c;
   logic [arcb_pkg::SEP_SUM_W-1:0]   s_c;
   logic [arcb_pkg::APROD_W-1:0]     aprod_c;
   logic [arcb_pkg::APROD_W-1:0]     ashift_c;
   logic [CW-1:0]                    alpha_c;
   logic [arcb_pkg::PIX_W-1:0]       word_c;

   // Memory and divider connections.
   logic                             mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0]                mem_rd_addr;
   logic [arcb_pkg::PIX_W-1:0]       mem_rd_data;
   logic                             div_start;
   logic [NUM_W-1:0]                 div_num [NCH];
   logic [DEN_W-1:0]                 div_den;
   arcb_pkg::div_status_type         div_status;
   logic [arcb_pkg::QUOT_W-1:0]      div_quot [NCH];

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_size_ff <= arcb_pkg::FRAME_SIZE_RESET;
         threshold_ff  <= arcb_pkg::THRESHOLD_RESET;
      end else if (csr_valid) begin
         unique case (arcb_pkg::csr_index_type'(csr_index))
            arcb_pkg::CSR_FRAME_SIZE: frame_size_ff <= csr_data;
            arcb_pkg::CSR_THRESHOLD:  threshold_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // A frame size write asks for the output position to be rebuilt from the count.
   assign realign_in = (csr_valid
                        && (arcb_pkg::csr_index_type'(csr_index) == arcb_pkg::CSR_FRAME_SIZE))
                       || (realign_ff && (state_ff != arcb_pkg::ST_IDLE));

   // Frame geometry: clamp the size, then the pixel count and the output lag.
   always_comb begin
      if (frame_size_ff == '0) begin
         size_c = DIM_W'(1);
      end else if (32'(frame_size_ff) > MAX_DIM) begin
         size_c = DIM_W'(MAX_DIM);
      end else begin
         size_c = DIM_W'(frame_size_ff);
      end
      total_c   = CNT_W'(size_c) * CNT_W'(size_c);
      lag_c     = CNT_W'(WINDOW_RADIUS) * CNT_W'(size_c) + CNT_W'(WINDOW_RADIUS);
      restart_c = ({1'b0, count_ff} >= ({1'b0, total_c} + {1'b0, lag_c}));
      lag_a     = ADDR_W'(lag_c);
      lag2_a    = ADDR_W'({lag_c, 1'b0});
      sm1_c     = $signed({2'b00, size_c}) - $signed(CRD_W'(1));
      fy0_c     = $signed({2'b00, oy_ff}) - $signed(CRD_W'(WINDOW_RADIUS));
      fx0_c     = $signed({2'b00, ox_ff}) - $signed(CRD_W'(WINDOW_RADIUS));
      last_c    = (ox_ff == size_c - 1'b1) && (oy_ff == size_c - 1'b1);
   end

   // Store addresses, all modulo the store depth.
   always_comb begin
      wp_next_c  = (wp_ff == ADDR_W'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      tmp_center = {1'b0, wp_ff} + (ADDR_W+1)'(DEPTH) - {1'b0, lag_a};
      if (tmp_center >= (ADDR_W+1)'(DEPTH)) begin
         tmp_center = tmp_center - (ADDR_W+1)'(DEPTH);
      end
      center_c  = tmp_center[ADDR_W-1:0];
      tmp_start = {1'b0, wp_ff} + (ADDR_W+1)'(DEPTH) - {1'b0, lag2_a};
      if (tmp_start >= (ADDR_W+1)'(DEPTH)) begin
         tmp_start = tmp_start - (ADDR_W+1)'(DEPTH);
      end
      start_c = tmp_start[ADDR_W-1:0];
      if (32'(size_c) >= 2 * WINDOW_RADIUS) begin
         row_inc_c = (ADDR_W+1)'(size_c) - (ADDR_W+1)'(2 * WINDOW_RADIUS);
      end else begin
         row_inc_c = (ADDR_W+1)'(size_c) + (ADDR_W+1)'(DEPTH - 2 * WINDOW_RADIUS);
      end
      if (wj_ff == WI_W'(WIN - 1)) begin
         step_sum = {1'b0, waddr_ff} + row_inc_c;
      end else begin
         step_sum = {1'b0, waddr_ff} + 1'b1;
      end
      if (step_sum >= (ADDR_W+1)'(DEPTH)) begin
         step_sum = step_sum - (ADDR_W+1)'(DEPTH);
      end
      pos_ok_c = !fy_ff[CRD_W-1] && (fy_ff < sm1_c) && !fx_ff[CRD_W-1] && (fx_ff < sm1_c);
   end

   // Separation: alpha sum, alpha and the stored word.
   always_comb begin
      s_c = '0;
      for (int k = 0; k < NCH; k++) begin
         s_c = s_c + arcb_pkg::SEP_SUM_W'(arcb_pkg::CHAN_MAX) + arcb_pkg::SEP_SUM_W'(blk_ff[k])
               - arcb_pkg::SEP_SUM_W'(wht_ff[k]);
      end
      aprod_c  = arcb_pkg::APROD_W'(s_c) * arcb_pkg::APROD_W'(arcb_pkg::ALPHA_RECIP);
      ashift_c = aprod_c >> arcb_pkg::ALPHA_SHIFT;
      alpha_c  = (ashift_c > arcb_pkg::APROD_W'(arcb_pkg::CHAN_MAX)) ? {CW{1'b1}}
                                                                     : ashift_c[CW-1:0];
      if (act_ff || s_ff == '0) begin
         word_c = '0;
      end else begin
         word_c = {alpha_ff, div_quot[2], div_quot[1], div_quot[0]};
      end
   end

   // Divider operands: color separation or window averages.
   always_comb begin
      div_start = (state_ff == arcb_pkg::ST_SEP) || (state_ff == arcb_pkg::ST_WSTART);
      if (state_ff == arcb_pkg::ST_SEP) begin
         for (int k = 0; k < NCH; k++) begin
            div_num[k] = NUM_W'(blk_ff[k]) * NUM_W'(arcb_pkg::COLOR_SCALE);
         end
         div_den = DEN_W'(s_c);
      end else begin
         for (int k = 0; k < NCH; k++) begin
            div_num[k] = NUM_W'(sum_ff[k]);
         end
         div_den = DEN_W'(wcnt_ff);
      end
   end

   // Sequencer: next state, store accesses and result assembly.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      align_in     = align_ff;
      wp_in        = wp_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      act_in       = act_ff;
      blk_in       = blk_ff;
      wht_in       = wht_ff;
      s_in         = s_ff;
      alpha_in     = alpha_ff;
      res_in       = res_ff;
      res_a_in     = res_a_ff;
      waddr_in     = waddr_ff;
      wi_in        = wi_ff;
      wj_in        = wj_ff;
      fy_in        = fy_ff;
      fx_in        = fx_ff;
      tap_in       = 1'b0;
      sum_in       = sum_ff;
      wcnt_in      = wcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = waddr_ff;
      req_tready   = (state_ff == arcb_pkg::ST_IDLE) && !realign_ff;

      // Accumulate the window entry read in the previous cycle.
      if (tap_ff && mem_rd_data[arcb_pkg::PIX_W-1 -: CW] > threshold_ff) begin
         for (int k = 0; k < NCH; k++) begin
            sum_in[k] = sum_ff[k] + SUM_W'(mem_rd_data[k*CW +: CW]);
         end
         wcnt_in = wcnt_ff + 1'b1;
      end

      unique case (state_ff)
         arcb_pkg::ST_IDLE: begin
            if (realign_ff) begin
               // The size changed: rebuild the output position from the item count.
               ox_in    = '0;
               oy_in    = '0;
               align_in = count_ff - lag_c;
               if (!restart_c && count_ff >= lag_c) begin
                  state_in = arcb_pkg::ST_ALIGN;
               end
            end else if (req_tvalid) begin
               act_in = req_tuser;
               for (int k = 0; k < NCH; k++) begin
                  blk_in[k] = req_tdata[k*CW +: CW];
                  wht_in[k] = req_tdata[(k+NCH)*CW +: CW];
               end
               // A size change can leave the count past the frame: start over.
               if (restart_c) begin
                  count_in = '0;
                  wp_in    = '0;
                  ox_in    = '0;
                  oy_in    = '0;
               end
               state_in = arcb_pkg::ST_SEP;
            end
         end
         arcb_pkg::ST_ALIGN: begin
            // Row by row subtraction of the width gives the output row and column.
            if (align_ff >= CNT_W'(size_c)) begin
               align_in = align_ff - CNT_W'(size_c);
               oy_in    = oy_ff + 1'b1;
            end else begin
               ox_in    = align_ff[DIM_W-1:0];
               state_in = arcb_pkg::ST_IDLE;
            end
         end
         arcb_pkg::ST_SEP: begin
            s_in     = s_c;
            alpha_in = alpha_c;
            state_in = arcb_pkg::ST_SDIV;
         end
         arcb_pkg::ST_SDIV: begin
            if (div_status.done) begin
               state_in = arcb_pkg::ST_WRITE;
            end
         end
         arcb_pkg::ST_WRITE: begin
            mem_wr_en = (count_ff < total_c);
            if (count_ff < lag_c) begin
               count_in = count_ff + 1'b1;
               wp_in    = wp_next_c;
               state_in = arcb_pkg::ST_IDLE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = center_c;
               state_in    = arcb_pkg::ST_CTR;
            end
         end
         arcb_pkg::ST_CTR: begin
            if (mem_rd_data[arcb_pkg::PIX_W-1 -: CW] > threshold_ff) begin
               for (int k = 0; k < NCH; k++) begin
                  res_in[k] = mem_rd_data[k*CW +: CW];
               end
               res_a_in = mem_rd_data[arcb_pkg::PIX_W-1 -: CW];
               state_in = arcb_pkg::ST_EMIT;
            end else begin
               waddr_in = start_c;
               wi_in    = '0;
               wj_in    = '0;
               fy_in    = fy0_c;
               fx_in    = fx0_c;
               for (int k = 0; k < NCH; k++) begin
                  sum_in[k] = '0;
               end
               wcnt_in  = '0;
               state_in = arcb_pkg::ST_WIN;
            end
         end
         arcb_pkg::ST_WIN: begin
            mem_rd_en = 1'b1;
            tap_in    = pos_ok_c;
            waddr_in  = step_sum[ADDR_W-1:0];
            if (wj_ff == WI_W'(WIN - 1)) begin
               wj_in = '0;
               fx_in = fx0_c;
               wi_in = wi_ff + 1'b1;
               fy_in = fy_ff + $signed(CRD_W'(1));
               if (wi_ff == WI_W'(WIN - 1)) begin
                  state_in = arcb_pkg::ST_WTAIL;
               end
            end else begin
               wj_in = wj_ff + 1'b1;
               fx_in = fx_ff + $signed(CRD_W'(1));
            end
         end
         arcb_pkg::ST_WTAIL: begin
            state_in = arcb_pkg::ST_WSTART;
         end
         arcb_pkg::ST_WSTART: begin
            state_in = arcb_pkg::ST_WDIV;
         end
         arcb_pkg::ST_WDIV: begin
            if (div_status.done) begin
               for (int k = 0; k < NCH; k++) begin
                  res_in[k] = (wcnt_ff == '0) ? '0 : div_quot[k];
               end
               res_a_in = '0;
               state_in = arcb_pkg::ST_EMIT;
            end
         end
         arcb_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_a_ff, res_ff[2], res_ff[1], res_ff[0]};
               rsp_last_in  = last_c;
               if (last_c) begin
                  count_in = '0;
                  wp_in    = '0;
                  ox_in    = '0;
                  oy_in    = '0;
               end else begin
                  count_in = count_ff + 1'b1;
                  wp_in    = wp_next_c;
                  if (ox_ff == size_c - 1'b1) begin
                     ox_in = '0;
                     oy_in = oy_ff + 1'b1;
                  end else begin
                     ox_in = ox_ff + 1'b1;
                  end
               end
               state_in = arcb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = arcb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= arcb_pkg::ST_IDLE;
         count_ff     <= '0;
         wp_ff        <= '0;
         ox_ff        <= '0;
         oy_ff        <= '0;
         tap_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         realign_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wp_ff        <= wp_in;
         ox_ff        <= ox_in;
         oy_ff        <= oy_in;
         tap_ff       <= tap_in;
         rsp_valid_ff <= rsp_valid_in;
         realign_ff   <= realign_in;
      end
      align_ff    <= align_in;
      act_ff      <= act_in;
      blk_ff      <= blk_in;
      wht_ff      <= wht_in;
      s_ff        <= s_in;
      alpha_ff    <= alpha_in;
      res_ff      <= res_in;
      res_a_ff    <= res_a_in;
      waddr_ff    <= waddr_in;
      wi_ff       <= wi_in;
      wj_ff       <= wj_in;
      fy_ff       <= fy_in;
      fx_ff       <= fx_in;
      sum_ff      <= sum_in;
      wcnt_ff     <= wcnt_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Pixel store, one word per raster position modulo the depth.
   arcb_ram #(
      .WIDTH (arcb_pkg::PIX_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wp_ff),
      .wr_data (word_c),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Shared divider for color separation and window averages.
   arcb_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .status (div_status),
      .quot   (div_quot)
   );

endmodule

// ===== rtl/core/arcb_checker.sv =====
// Port-level checker of the alpha recovery core, bound to the top level.
// Depends on arcb_pkg and the assertion macro header.
`include "alpha_recover_and_color_bleed_core_macros.svh"

module arcb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [arcb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast,
   input logic                            csr_ready
);

   // A stalled result keeps its value.
   `ARCB_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result dropped or changed while stalled")

   // Requests are worked one at a time, so ready drops after each request.
   `ARCB_ASSERT(a_req_gap, clock, reset, req_tvalid && req_tready |=> !req_tready && !$rose(rsp_tvalid), "request taken while another is in work")

   // Reset empties the output register.
   `ARCB_ASSERT_ON(a_rsp_reset, clock, reset |=> !rsp_tvalid, "result pending after reset")

   // Configuration writes are never refused.
   `ARCB_ASSERT(a_csr_open, clock, reset, csr_ready, "configuration port not ready")

endmodule

bind alpha_recover_and_color_bleed_core arcb_checker u_arcb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_ready  (csr_ready)
);
